// ----- rtl/core/lru_key_value_cache_defines.svh -----
// Assertion macros used by the assertion checker of the cache.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define LKV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lkv assertion failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lkv assertion failed");

`endif

// ----- rtl/core/lkv_pkg.sv -----
`default_nettype none

package lkv_pkg;

  // Store geometry.
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RANK_W  = IDX_W;
  localparam int unsigned OCC_W   = $clog2(ENTRIES + 1);

  // Field widths.
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  // Request codes.
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic lookup;
    logic update;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/lru_key_value_cache.sv -----
// LRU key/value cache, 16 fully associative entries.
// A request is captured in IDLE and looked up in LOOKUP, and its result beat is
// registered in UPDATE, which waits while a stalled result still holds the register.
// Only one request is in flight; a new one is taken only after UPDATE returns to IDLE.
// Reset (asynchronous, active low) empties the store and sets capacity to 16.
`default_nettype none

module lru_key_value_cache
  import lkv_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic        [CAP_W-1:0] cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    req_type_i,
  input  wire logic        [KEY_W-1:0] key_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         found_o,
  output logic signed      [VAL_W-1:0] read_value_o
);

  ctrl_cmd_t cmd;

  // Sequencing of one request at a time.
  lkv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Tag store, recency ranks and result register.
  lkv_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .found_o      (found_o),
    .read_value_o (read_value_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/lkv_ctrl.sv -----
`default_nettype none

module lkv_ctrl
  import lkv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can take a new beat when empty or drained this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_stall_o   = 1'b1;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
      end
      ST_UPDATE: begin
        cmd_o.update = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Result valid is set by an update and cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.update) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lkv_dp.sv -----
`default_nettype none

module lkv_dp
  import lkv_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ctrl_cmd_t               cmd_i,
  input  wire logic                    cfg_we_i,
  input  wire logic        [CAP_W-1:0] cfg_wdata_i,
  input  wire logic                    req_type_i,
  input  wire logic        [KEY_W-1:0] key_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  output logic                         found_o,
  output logic signed      [VAL_W-1:0] read_value_o
);

  // Request registers.
  logic                    req_type_q;
  logic        [KEY_W-1:0] key_q;
  logic signed [VAL_W-1:0] value_q;

  // Store contents.
  logic        [KEY_W-1:0]  keys_q   [ENTRIES];
  logic signed [VAL_W-1:0]  values_q [ENTRIES];
  logic        [ENTRIES-1:0] valid_q, valid_d;
  logic        [RANK_W-1:0] rank_q   [ENTRIES];
  logic        [RANK_W-1:0] rank_d   [ENTRIES];
  logic        [OCC_W-1:0]  occ_q, occ_d;
  logic        [CAP_W-1:0]  cap_q;

  // Lookup results.
  logic             hit_d, hit_q;
  logic [IDX_W-1:0] slot_d, slot_q;
  logic [IDX_W-1:0] victim_d, victim_q;
  logic [IDX_W-1:0] free_d, free_q;
  logic             full_d, full_q;
  logic [OCC_W-1:0] eff_cap;

  // Result register.
  logic                    found_q;
  logic signed [VAL_W-1:0] read_value_q;

  // Write port of the key and value arrays.
  logic             key_we, val_we;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] ins_idx;
  logic [RANK_W-1:0] touch_rank;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Zero acts as one, anything above the store size acts as the store size.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = OCC_W'(1);
    end else if (cap_q > CAP_W'(ENTRIES)) begin
      eff_cap = OCC_W'(ENTRIES);
    end else begin
      eff_cap = OCC_W'(cap_q);
    end
  end

  // Capture the request beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_type_i;
      key_q      <= key_i;
      value_q    <= value_i;
    end
  end

  // Parallel key compare, least recent search and free slot search.
  // Valid ranks are a permutation of 0 to occupancy-1, so the least recent
  // entry is the valid one whose rank equals occupancy-1.
  always_comb begin
    hit_d    = 1'b0;
    slot_d   = '0;
    victim_d = '0;
    free_d   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && keys_q[i] == key_q) begin
        hit_d  = 1'b1;
        slot_d = IDX_W'(i);
      end
      if (valid_q[i] && rank_q[i] == RANK_W'(occ_q - OCC_W'(1))) begin
        victim_d = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_d = IDX_W'(i);
      end
    end
    full_d = (occ_q >= eff_cap);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q    <= hit_d;
      slot_q   <= slot_d;
      victim_q <= victim_d;
      free_q   <= free_d;
      full_q   <= full_d;
    end
  end

  // Slot that a new key goes into: the victim when full, else a free slot.
  assign ins_idx    = full_q ? victim_q : free_q;
  assign touch_rank = rank_q[slot_q];

  // Recency, valid and occupancy updates.
  always_comb begin
    rank_d  = rank_q;
    valid_d = valid_q;
    occ_d   = occ_q;
    if (cmd_i.update) begin
      if (hit_q) begin
        // Move the hit entry to the front; more recent entries age by one.
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && IDX_W'(i) != slot_q && rank_q[i] < touch_rank) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
        end
        rank_d[slot_q] = '0;
      end else if (req_type_q == REQ_PUT) begin
        // Insert at the front; every surviving entry ages by one.
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && !(full_q && IDX_W'(i) == victim_q)) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
        end
        rank_d[ins_idx]  = '0;
        valid_d[ins_idx] = 1'b1;
        if (!full_q) occ_d = occ_q + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      rank_q  <= rank_d;
    end
  end

  // Key and value writes: a put updates in place on a hit, else inserts.
  assign key_we = cmd_i.update && (req_type_q == REQ_PUT) && !hit_q;
  assign val_we = cmd_i.update && (req_type_q == REQ_PUT);
  assign wr_idx = hit_q ? slot_q : ins_idx;

  always_ff @(posedge clk_i) begin
    if (key_we) keys_q[wr_idx] <= key_q;
    if (val_we) values_q[wr_idx] <= value_q;
  end

  // Result beat: stored value on a get hit, all ones otherwise.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      found_q <= hit_q;
      if (hit_q && req_type_q == REQ_GET) begin
        read_value_q <= values_q[slot_q];
      end else begin
        read_value_q <= '1;
      end
    end
  end

  assign found_o      = found_q;
  assign read_value_o = read_value_q;

endmodule

`default_nettype wire

// ----- rtl/core/lkv_checker.sv -----
`default_nettype none
`include "lru_key_value_cache_defines.svh"

module lkv_checker
  import lkv_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic                    found_o,
  input wire logic signed [VAL_W-1:0] read_value_o
);

  // A stalled result beat stays offered.
  `LKV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A miss always reports all ones.
  `LKV_ASSERT_IMPLY(a_miss_value, clk_i, rst_ni, out_valid_o && !found_o, read_value_o == '1)

  // One request at a time: the input stalls right after a beat is taken.
  `LKV_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A new result appears only while a request was being worked on.
  `LKV_ASSERT_IMPLY(a_result_origin, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire

// ----- bench/lru_cache_checker.sv -----
// Watches both channels of the cache and predicts each reply.
module lru_cache_checker
  import lkv_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic        [CAP_W-1:0] cfg_wdata_i,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_stall_i,
  input  wire logic                    req_type_i,
  input  wire logic        [KEY_W-1:0] key_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic                    out_valid_i,
  input  wire logic                    out_stall_i,
  input  wire logic                    found_i,
  input  wire logic signed [VAL_W-1:0] read_value_i,
  output int                           pending_o,
  output int                           fail_count_o
);

  // One predicted reply, with the key kept for messages only.
  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } cache_reply_t;

  // Shadow copy of the tag store and its recency ranks.
  logic [KEY_W-1:0]        slot_key   [ENTRIES];
  logic signed [VAL_W-1:0] slot_value [ENTRIES];
  logic                    slot_used  [ENTRIES];
  logic [RANK_W-1:0]       slot_rank  [ENTRIES];
  logic [OCC_W-1:0]        used_count;
  logic [CAP_W-1:0]        capacity_reg;
  cache_reply_t            reply_q [$];

  // Counts a mismatch and prints one line for it.
  task automatic report_mismatch(input string msg);
    fail_count_o = fail_count_o + 1;
    $display("[%0t] lru check: %s", $time, msg);
  endtask

  // Runs one request against the shadow store and returns its reply.
  function automatic cache_reply_t serve_request(input logic is_put,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic signed [VAL_W-1:0] v);
    cache_reply_t      r;
    int                hit_slot;
    int                victim;
    int                cap_eff;
    logic [RANK_W-1:0] old_rank;
    hit_slot     = -1;
    r.key        = k;
    r.read_value = '1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_slot < 0 && slot_used[i] && slot_key[i] == k) hit_slot = i;
    end
    r.found = (hit_slot >= 0);

    if (hit_slot >= 0) begin
      // A hit refreshes the entry; entries newer than it age by one.
      if (is_put == REQ_PUT) slot_value[hit_slot] = v;
      else r.read_value = slot_value[hit_slot];
      old_rank = slot_rank[hit_slot];
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && i != hit_slot && slot_rank[i] < old_rank) begin
          slot_rank[i] = slot_rank[i] + RANK_W'(1);
        end
      end
      slot_rank[hit_slot] = '0;
    end else if (is_put == REQ_PUT) begin
      // Capacity is clamped to the range one to the number of entries.
      cap_eff = int'(capacity_reg);
      if (cap_eff < 1) cap_eff = 1;
      if (cap_eff > ENTRIES) cap_eff = ENTRIES;
      victim = -1;
      if (int'(used_count) >= cap_eff) begin
        // Full: drop the least recent entry and reuse its slot.
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
        end
        slot_used[victim] = 1'b0;
        used_count        = used_count - OCC_W'(1);
      end else begin
        // Otherwise take the lowest free slot.
        for (int i = 0; i < ENTRIES; i++) begin
          if (victim < 0 && !slot_used[i]) victim = i;
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i]) slot_rank[i] = slot_rank[i] + RANK_W'(1);
      end
      slot_key[victim]   = k;
      slot_value[victim] = v;
      slot_used[victim]  = 1'b1;
      slot_rank[victim]  = '0;
      used_count         = used_count + OCC_W'(1);
    end
    return r;
  endfunction

  // Sample every beat at the clock edge: config, then replies, then requests.
  always @(posedge clk_i or negedge rst_ni) begin
    cache_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_used[i]  = 1'b0;
        slot_rank[i]  = '0;
      end
      used_count   = '0;
      capacity_reg = CAP_RESET;
      reply_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) capacity_reg = cfg_wdata_i;

      if (out_valid_i && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("reply beat with no request outstanding");
        end else begin
          want = reply_q.pop_front();
          if (found_i !== want.found) begin
            report_mismatch($sformatf("key %h: found %b, expected %b",
                                      want.key, found_i, want.found));
          end
          if (read_value_i !== want.read_value) begin
            report_mismatch($sformatf("key %h: read_value %0d, expected %0d",
                                      want.key, read_value_i, want.read_value));
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        reply_q.push_back(serve_request(req_type_i, key_i, value_i));
      end
      pending_o = reply_q.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  import lkv_pkg::*;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int PHASE_ITEMS    = 105;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic        [CAP_W-1:0] cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic                    req_type_i  = REQ_GET;
  logic        [KEY_W-1:0] key_i       = '0;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    found_o;
  logic signed [VAL_W-1:0] read_value_o;

  int          pending_replies;
  int          mismatch_count;
  int          burst_left = 0;
  bit          calm_phase = 1'b0;
  logic [1:0]  stall_mode = 2'd0;
  int unsigned stall_tick = 0;
  logic [KEY_W-1:0] key_pool [24];
  logic [CAP_W-1:0] cap_plan [10];

  lru_key_value_cache dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .read_value_o (read_value_o)
  );

  lru_cache_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_i      (found_o),
    .read_value_i (read_value_o),
    .pending_o    (pending_replies),
    .fail_count_o (mismatch_count)
  );

  // Free-running clock.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // The reply side stalls in one of four modes, picked anew whenever the low byte of the tick counter wraps.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[7:0] == 8'd255) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_tick[2];
    endcase
  end

  // Sends one request beat; a burst may start with a random gap, never in a calm phase.
  task automatic send_beat(input logic kind, input logic [KEY_W-1:0] k,
                           input logic signed [VAL_W-1:0] v);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!calm_phase && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 7);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    key_i      <= k;
    value_i    <= v;
    // The beat is taken at the first edge whose stall, seen mid-cycle, is low.
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  // Stops sending and waits until every reply has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_replies != 0);
    @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic over a key pool sized a little above the capacity, so
  // hits, updates and evictions all happen often.
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n);
    int                      eff;
    int                      pool_n;
    logic [KEY_W-1:0]        k;
    logic signed [VAL_W-1:0] v;
    write_capacity(cap);
    eff = int'(cap);
    if (eff < 1) eff = 1;
    if (eff > ENTRIES) eff = ENTRIES;
    pool_n = eff + $urandom_range(1, 6);
    if (pool_n > 24) pool_n = 24;
    // Part of the pool carries over, so keys stored earlier are looked up again.
    foreach (key_pool[i]) begin
      if ($urandom_range(0, 2) == 0) key_pool[i] = $urandom;
    end
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, pool_n - 1)];
      case ($urandom_range(0, 15))
        0:       v = {1'b1, {(VAL_W-1){1'b0}}};
        1:       v = {1'b0, {(VAL_W-1){1'b1}}};
        2:       v = '1;
        default: v = $urandom;
      endcase
      send_beat(($urandom_range(0, 1) == 1) ? REQ_PUT : REQ_GET, k, v);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    cap_plan = '{CAP_W'(16), CAP_W'(4), CAP_W'(1), CAP_W'(0), CAP_W'(31),
                 CAP_W'(3), CAP_W'(16), CAP_W'(2), CAP_W'(17), CAP_W'(8)};
    foreach (key_pool[i]) begin
      case ($urandom_range(0, 7))
        0:       key_pool[i] = '0;
        1:       key_pool[i] = '1;
        default: key_pool[i] = $urandom;
      endcase
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, extreme keys and values, update in place.
    send_beat(REQ_GET, '0, $urandom);
    send_beat(REQ_PUT, '0, {1'b1, {(VAL_W-1){1'b0}}});
    send_beat(REQ_PUT, '1, {1'b0, {(VAL_W-1){1'b1}}});
    send_beat(REQ_GET, '0, '0);
    send_beat(REQ_GET, '1, '0);
    send_beat(REQ_PUT, '0, '1);
    send_beat(REQ_GET, '0, $urandom);
    send_beat(REQ_GET, 32'h1234_5678, '1);
    send_beat(REQ_PUT, 32'h1234_5678, '0);
    send_beat(REQ_GET, 32'h1234_5678, 32'h5A5A_A5A5);

    // Directed: capacity dropped below occupancy, then new keys evict one each.
    write_capacity(CAP_W'(2));
    send_beat(REQ_PUT, 32'hA5A5_0001, 32'sd11);
    send_beat(REQ_GET, '1, '0);
    send_beat(REQ_GET, '0, '0);
    send_beat(REQ_PUT, 32'h5A5A_0002, 32'sd22);
    send_beat(REQ_GET, 32'h1234_5678, '0);
    send_beat(REQ_PUT, '0, 32'sd33);
    send_beat(REQ_GET, 32'hA5A5_0001, '0);
    send_beat(REQ_GET, 32'h5A5A_0002, '0);

    // Random phases, one capacity setting each.
    foreach (cap_plan[p]) begin
      calm_phase = (p % 4 == 1);
      run_phase(cap_plan[p], PHASE_ITEMS);
    end

    wait_idle();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("** lru_key_value_cache: PASSED **");
    end else begin
      $display("** lru_key_value_cache: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(8 * TIMEOUT_CYCLES);
    $display("** lru_key_value_cache: FAILED **");
    $finish;
  end

endmodule

// ----- lru_key_value_cache.f -----
+incdir+rtl/core
rtl/core/lkv_pkg.sv
rtl/core/lkv_ctrl.sv
rtl/core/lkv_dp.sv
rtl/core/lru_key_value_cache.sv
rtl/core/lkv_checker.sv
bench/lru_cache_checker.sv
bench/tb.sv
